/* design/line_segment_intersection_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the line segment intersection block
// Concurrent checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`define LINE_SEGMENT_INTERSECTION_TOP_ASSERT_SVH
`ifndef SYNTH
`define LSI_CHECK(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lsi check failed");
`define LSI_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsi sequence check failed");
`else
`define LSI_CHECK(label, clk, rst, cond)
`define LSI_CHECK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/lsi_pkg.sv */
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants of the line segment intersection block.
// ----------------------------------------------------------------------------
`default_nettype none
package lsi_pkg;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;
   localparam logic SEG_MODE_RESET = 1'b1;

endpackage
`default_nettype wire

/* design/line_segment_intersection_top.sv */
// ----------------------------------------------------------------------------
// line_segment_intersection_top
// Exact 2D segment or line intersection with rounded, saturated result.
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while req_full is low and returns one result
// per pair, in order. A pair passes three front stages of differences, products
// and classification, the middle queue, then COORD_WIDTH + 8 back stages set
// by the restoring divider that resolves one quotient bit per stage in each of
// the two coordinate lanes, and the output queue. segment_mode is written
// through the csr channel, which is always ready.
`default_nettype none
module line_segment_intersection_top #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output      logic                          req_full,
   input  wire logic signed [COORD_WIDTH-1:0] req_p1_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_p1_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_p2_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_p2_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_p3_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_p3_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_p4_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_p4_y,
   output      logic                          rsp_empty,
   input  wire logic                          rsp_pop,
   output      logic                          rsp_hit,
   output      logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output      logic signed [COORD_WIDTH-1:0] rsp_cross_y,
   output      logic                          rsp_clipped,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic                          csr_segment_mode
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int PW = 2 * W + 3;
   localparam int MQW = 1 + 2 * PW + 2 * DW + 2 * W;
   localparam int OQW = 2 + 2 * W;

   lsi_pkg::fifo_status_type mid_status, out_status;
   logic front_en, back_en, mid_push, mid_pop, out_push;
   logic [MQW-1:0] mid_din, mid_dout;
   logic [OQW-1:0] out_din, out_dout;
   logic f_hit, b_hit, b_hit_out, b_clip;
   logic signed [PW-1:0] f_den, f_tn, b_den, b_tn;
   logic signed [DW-1:0] f_dx, f_dy, b_dx, b_dy;
   logic signed [W-1:0]  f_px, f_py, b_px, b_py, b_cx, b_cy;

   // stall each side only on the queue it feeds
   assign front_en  = !mid_status.full;
   assign back_en   = !out_status.full;
   assign req_full  = !front_en;
   assign csr_ready = 1'b1;

   lsi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .csr_write(csr_valid && csr_ready), .csr_data(csr_segment_mode),
      .enable(front_en), .take(req_push && front_en),
      .p1_x(req_p1_x), .p1_y(req_p1_y), .p2_x(req_p2_x), .p2_y(req_p2_y),
      .p3_x(req_p3_x), .p3_y(req_p3_y), .p4_x(req_p4_x), .p4_y(req_p4_y),
      .push(mid_push), .hit(f_hit), .den(f_den), .tn(f_tn),
      .dx(f_dx), .dy(f_dy), .px(f_px), .py(f_py)
   );

   assign mid_din = {f_hit, f_den, f_tn, f_dx, f_dy, f_px, f_py};

   lsi_queue #(.WIDTH(MQW), .DEPTH(lsi_pkg::MID_DEPTH)) u_mid_q (
      .clock(clock), .reset(reset), .push(mid_push), .din(mid_din),
      .pop(mid_pop), .dout(mid_dout), .status(mid_status)
   );

   assign mid_pop = back_en && !mid_status.empty;
   assign {b_hit, b_den, b_tn, b_dx, b_dy, b_px, b_py} = mid_dout;

   lsi_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset), .enable(back_en), .take(mid_pop),
      .hit(b_hit), .den(b_den), .tn(b_tn), .dx(b_dx), .dy(b_dy),
      .px(b_px), .py(b_py), .push(out_push), .out_hit(b_hit_out),
      .cross_x(b_cx), .cross_y(b_cy), .clipped(b_clip)
   );

   assign out_din = {b_hit_out, b_cx, b_cy, b_clip};

   lsi_queue #(.WIDTH(OQW), .DEPTH(lsi_pkg::OUT_DEPTH)) u_out_q (
      .clock(clock), .reset(reset), .push(out_push), .din(out_din),
      .pop(rsp_pop && !out_status.empty), .dout(out_dout), .status(out_status)
   );

   assign rsp_empty = out_status.empty;
   assign {rsp_hit, rsp_cross_x, rsp_cross_y, rsp_clipped} = out_dout;
endmodule
`default_nettype wire

/* design/lsi_queue.sv */
// ----------------------------------------------------------------------------
// lsi_queue
// Small register FIFO with a combinational head read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_segment_intersection_top_assert.svh"
module lsi_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] dout,
   output      lsi_pkg::fifo_status_type status
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

   `LSI_CHECK(q_no_overflow, clock, reset, !(push && status.full))
   `LSI_CHECK(q_no_underflow, clock, reset, !(pop && status.empty))
   `LSI_CHECK_NEXT(q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)
endmodule
`default_nettype wire

/* design/lsi_front.sv */
// ----------------------------------------------------------------------------
// lsi_front
// Forms directions and cross products and classifies each segment pair.
// ----------------------------------------------------------------------------
`default_nettype none
module lsi_front #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic                          csr_data,
   input  wire logic                          enable,
   input  wire logic                          take,
   input  wire logic signed [COORD_WIDTH-1:0] p1_x,
   input  wire logic signed [COORD_WIDTH-1:0] p1_y,
   input  wire logic signed [COORD_WIDTH-1:0] p2_x,
   input  wire logic signed [COORD_WIDTH-1:0] p2_y,
   input  wire logic signed [COORD_WIDTH-1:0] p3_x,
   input  wire logic signed [COORD_WIDTH-1:0] p3_y,
   input  wire logic signed [COORD_WIDTH-1:0] p4_x,
   input  wire logic signed [COORD_WIDTH-1:0] p4_y,
   output      logic                          push,
   output      logic                          hit,
   output      logic signed [2*COORD_WIDTH+2:0] den,
   output      logic signed [2*COORD_WIDTH+2:0] tn,
   output      logic signed [COORD_WIDTH:0]   dx,
   output      logic signed [COORD_WIDTH:0]   dy,
   output      logic signed [COORD_WIDTH-1:0] px,
   output      logic signed [COORD_WIDTH-1:0] py
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int MW = 2 * DW;
   localparam int PW = 2 * W + 3;

   logic            mode_ff;
   logic [2:0]      valid_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, ex1_ff, ey1_ff, fx1_ff, fy1_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic signed [W-1:0]  px1_ff, py1_ff, px2_ff, py2_ff, px3_ff, py3_ff;
   logic signed [MW-1:0] m_ff [6];
   logic signed [PW-1:0] den_ff, tn_ff, un_ff;
   logic signed [PW-1:0] den_n, tn_n, un_n;
   logic            seg_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lsi_pkg::SEG_MODE_RESET;
         valid_ff <= '0;
      end else begin
         if (csr_write) begin
            mode_ff <= csr_data;
         end
         if (enable) begin
            valid_ff <= {valid_ff[1:0], take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx1_ff <= DW'(p2_x) - DW'(p1_x);
         dy1_ff <= DW'(p2_y) - DW'(p1_y);
         ex1_ff <= DW'(p4_x) - DW'(p3_x);
         ey1_ff <= DW'(p4_y) - DW'(p3_y);
         fx1_ff <= DW'(p3_x) - DW'(p1_x);
         fy1_ff <= DW'(p3_y) - DW'(p1_y);
         px1_ff <= p1_x;
         py1_ff <= p1_y;
         m_ff[0] <= dx1_ff * ey1_ff;
         m_ff[1] <= dy1_ff * ex1_ff;
         m_ff[2] <= fx1_ff * ey1_ff;
         m_ff[3] <= fy1_ff * ex1_ff;
         m_ff[4] <= fx1_ff * dy1_ff;
         m_ff[5] <= fy1_ff * dx1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         px2_ff <= px1_ff;
         py2_ff <= py1_ff;
         den_ff <= PW'(m_ff[0]) - PW'(m_ff[1]);
         tn_ff  <= PW'(m_ff[2]) - PW'(m_ff[3]);
         un_ff  <= PW'(m_ff[4]) - PW'(m_ff[5]);
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         px3_ff <= px2_ff;
         py3_ff <= py2_ff;
      end
   end

   // flip signs so the denominator is positive, then test 0 <= num <= den
   always_comb begin
      den_n  = den_ff[PW-1] ? -den_ff : den_ff;
      tn_n   = den_ff[PW-1] ? -tn_ff : tn_ff;
      un_n   = den_ff[PW-1] ? -un_ff : un_ff;
      seg_ok = !tn_n[PW-1] && (tn_n <= den_n) && !un_n[PW-1] && (un_n <= den_n);
   end

   assign push = valid_ff[2] && enable;
   assign hit  = (den_ff != '0) && (!mode_ff || seg_ok);
   assign den  = den_ff;
   assign tn   = tn_ff;
   assign dx   = dx3_ff;
   assign dy   = dy3_ff;
   assign px   = px3_ff;
   assign py   = py3_ff;
endmodule
`default_nettype wire

/* design/lsi_lane.sv */
// ----------------------------------------------------------------------------
// lsi_lane
// One coordinate: p + tn*dc/den, rounded half away from zero and saturated,
// through a one-bit-per-stage restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module lsi_lane #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            enable,
   input  wire logic signed [2*COORD_WIDTH+2:0] tn,
   input  wire logic signed [2*COORD_WIDTH+2:0] den,
   input  wire logic signed [COORD_WIDTH:0]     dc,
   input  wire logic signed [COORD_WIDTH-1:0]   p,
   output      logic signed [COORD_WIDTH-1:0]   coord,
   output      logic                            clip
);
   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W + 3;
   localparam int Q  = W + 2;
   localparam int NW = 3 * W + 4;
   localparam int BW = W + 4;
   localparam longint MAXL = (longint'(1) <<< (W - 1)) - 1;
   localparam logic signed [BW-1:0] MAXV = BW'(MAXL);
   localparam logic signed [BW-1:0] MINV = -MAXV - 1;

   // partial products
   logic signed [2*W+3:0] lo_prod_ff;
   logic signed [2*W+1:0] hi_prod_ff;
   logic signed [PW-1:0]  den1_ff, den2_ff;
   logic signed [W-1:0]   p1_ff, p2_ff, p3_ff;
   logic signed [NW-1:0]  n_ff, hi_ext;
   logic [NW-1:0]         a_ff;
   logic [PW-1:0]         b3_ff;
   logic                  s3_ff;

   // divider stages, index 0 is the setup stage
   logic [PW-1:0]         r_ff  [Q+1];
   logic [PW-1:0]         b_ff  [Q+1];
   logic [Q-1:0]          ab_ff [Q+1];
   logic [Q-1:0]          q_ff  [Q+1];
   logic                  s_ff  [Q+1];
   logic                  big_ff [Q+1];
   logic signed [W-1:0]   pp_ff [Q+1];

   // rounding
   logic signed [BW-1:0]  qe, fl, base_in, base_ff, v;
   logic [PW-1:0]         fr;
   logic [PW:0]           twofr;
   logic                  gt_ff, eq_ff, big5_ff, s5_ff, up;
   logic signed [W-1:0]   coord_ff, coord_in;
   logic                  clip_ff, clip_in;

   assign hi_ext = NW'(hi_prod_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_prod_ff <= $signed({1'b0, tn[Q-1:0]}) * dc;
         hi_prod_ff <= $signed(tn[PW-1:Q]) * dc;
         den1_ff    <= den;
         p1_ff      <= p;
         n_ff       <= (hi_ext <<< Q) + NW'(lo_prod_ff);
         den2_ff    <= den1_ff;
         p2_ff      <= p1_ff;
         s3_ff      <= n_ff[NW-1] ^ den2_ff[PW-1];
         a_ff       <= n_ff[NW-1] ? NW'(-n_ff) : NW'(n_ff);
         b3_ff      <= den2_ff[PW-1] ? PW'(-den2_ff) : PW'(den2_ff);
         p3_ff      <= p2_ff;
         // quotient beyond Q bits saturates regardless of p
         big_ff[0]  <= {1'b0, a_ff} >= ({{Q{1'b0}}, b3_ff} << Q);
         r_ff[0]    <= PW'(a_ff[NW-1:Q]);
         ab_ff[0]   <= a_ff[Q-1:0];
         q_ff[0]    <= '0;
         b_ff[0]    <= b3_ff;
         s_ff[0]    <= s3_ff;
         pp_ff[0]   <= p3_ff;
      end
   end

   for (genvar j = 0; j < Q; j++) begin : g_div
      logic [PW-1:0] t;
      logic          ge;
      assign t  = {r_ff[j][PW-2:0], ab_ff[j][Q-1]};
      assign ge = (t >= b_ff[j]);
      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff[j+1]   <= ge ? t - b_ff[j] : t;
            q_ff[j+1]   <= {q_ff[j][Q-2:0], ge};
            ab_ff[j+1]  <= {ab_ff[j][Q-2:0], 1'b0};
            b_ff[j+1]   <= b_ff[j];
            s_ff[j+1]   <= s_ff[j];
            big_ff[j+1] <= big_ff[j];
            pp_ff[j+1]  <= pp_ff[j];
         end
      end
   end

   // floor of the signed quotient and the fraction left over
   always_comb begin
      qe = $signed({{(BW-Q){1'b0}}, q_ff[Q]});
      if (!s_ff[Q]) begin
         fl = qe;
         fr = r_ff[Q];
      end else if (r_ff[Q] == '0) begin
         fl = -qe;
         fr = '0;
      end else begin
         fl = -qe - 1'b1;
         fr = b_ff[Q] - r_ff[Q];
      end
      twofr   = {fr, 1'b0};
      base_in = BW'(pp_ff[Q]) + fl;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         base_ff <= base_in;
         gt_ff   <= twofr > {1'b0, b_ff[Q]};
         eq_ff   <= twofr == {1'b0, b_ff[Q]};
         big5_ff <= big_ff[Q];
         s5_ff   <= s_ff[Q];
      end
   end

   // ties go up for a nonnegative base, down otherwise
   always_comb begin
      up = gt_ff || (eq_ff && !base_ff[BW-1]);
      v  = base_ff + $signed({{(BW-1){1'b0}}, up});
      priority if (big5_ff) begin
         clip_in  = 1'b1;
         coord_in = s5_ff ? MINV[W-1:0] : MAXV[W-1:0];
      end else if (v > MAXV) begin
         clip_in  = 1'b1;
         coord_in = MAXV[W-1:0];
      end else if (v < MINV) begin
         clip_in  = 1'b1;
         coord_in = MINV[W-1:0];
      end else begin
         clip_in  = 1'b0;
         coord_in = v[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         coord_ff <= coord_in;
         clip_ff  <= clip_in;
      end
   end

   assign coord = coord_ff;
   assign clip  = clip_ff;
endmodule
`default_nettype wire

/* design/lsi_back.sv */
// ----------------------------------------------------------------------------
// lsi_back
// Computes the intersection point of each classified pair in two lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module lsi_back #(
   parameter int COORD_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            enable,
   input  wire logic                            take,
   input  wire logic                            hit,
   input  wire logic signed [2*COORD_WIDTH+2:0] den,
   input  wire logic signed [2*COORD_WIDTH+2:0] tn,
   input  wire logic signed [COORD_WIDTH:0]     dx,
   input  wire logic signed [COORD_WIDTH:0]     dy,
   input  wire logic signed [COORD_WIDTH-1:0]   px,
   input  wire logic signed [COORD_WIDTH-1:0]   py,
   output      logic                            push,
   output      logic                            out_hit,
   output      logic signed [COORD_WIDTH-1:0]   cross_x,
   output      logic signed [COORD_WIDTH-1:0]   cross_y,
   output      logic                            clipped
);
   localparam int LL = COORD_WIDTH + 8;

   logic [LL-1:0] valid_ff, hit_ff;
   logic signed [COORD_WIDTH-1:0] lane_x, lane_y;
   logic          clip_x, clip_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[LL-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff <= {hit_ff[LL-2:0], hit};
      end
   end

   lsi_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
      .clock(clock), .enable(enable), .tn(tn), .den(den), .dc(dx), .p(px),
      .coord(lane_x), .clip(clip_x)
   );

   lsi_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
      .clock(clock), .enable(enable), .tn(tn), .den(den), .dc(dy), .p(py),
      .coord(lane_y), .clip(clip_y)
   );

   // drop the lane results for a miss
   assign push    = valid_ff[LL-1] && enable;
   assign out_hit = hit_ff[LL-1];
   assign cross_x = hit_ff[LL-1] ? lane_x : '0;
   assign cross_y = hit_ff[LL-1] ? lane_y : '0;
   assign clipped = hit_ff[LL-1] && (clip_x || clip_y);
endmodule
`default_nettype wire

/* dv/tb_line_segment_intersection_top.sv */
// ----------------------------------------------------------------------------
// Line segment intersection testbench
// Streams segment pairs through the queue-style ports under varying idle
// patterns and both mode settings. Every result beat is checked against an
// exact integer prediction of the hit flag, rounded crossing and clip flag.
// ----------------------------------------------------------------------------
`default_nettype none

typedef shortint seg_pair_type [8];   // x1 y1 x2 y2 x3 y3 x4 y4

typedef struct {
   bit      hit;
   shortint cross_x;
   shortint cross_y;
   bit      clipped;
} crossing_type;

class crossing_scoreboard;
   bit           seg_mode = 1'b1;
   crossing_type pending[$];
   int           mismatches;
   int           failures;

   // Exact check that num/den lies in [0,1].
   static function bit within_unit(longint num, longint den);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      return num >= 0 && num <= den;
   endfunction

   // Round (p*den + tn*dc)/den to nearest, ties away from zero, then saturate.
   static function shortint round_coord(longint p, longint tn, longint dc, longint den,
                                        inout bit clip);
      longint n, an, ad, q;
      n  = p * den + tn * dc;
      an = (n < 0) ? -n : n;
      ad = (den < 0) ? -den : den;
      q  = (2 * an + ad) / (2 * ad);
      if ((n < 0) != (den < 0)) q = -q;
      if (q > 32767) begin
         clip = 1'b1;
         q = 32767;
      end
      if (q < -32768) begin
         clip = 1'b1;
         q = -32768;
      end
      return shortint'(q);
   endfunction

   function crossing_type predict_crossing(seg_pair_type s);
      crossing_type r;
      longint dx, dy, ex, ey, fx, fy, den, tn, un;
      bit clip;
      r  = '{0, 0, 0, 0};
      dx = longint'(s[2]) - s[0];
      dy = longint'(s[3]) - s[1];
      ex = longint'(s[6]) - s[4];
      ey = longint'(s[7]) - s[5];
      fx = longint'(s[4]) - s[0];
      fy = longint'(s[5]) - s[1];
      den = dx * ey - dy * ex;
      tn  = fx * ey - fy * ex;
      un  = fx * dy - fy * dx;
      clip = 1'b0;
      if (den == 0) return r;
      if (seg_mode && (!within_unit(tn, den) || !within_unit(un, den))) return r;
      r.hit     = 1'b1;
      r.cross_x = round_coord(s[0], tn, dx, den, clip);
      r.cross_y = round_coord(s[1], tn, dy, den, clip);
      r.clipped = clip;
      return r;
   endfunction

   function void note_pair(seg_pair_type s);
      pending.push_back(predict_crossing(s));
   endfunction

   function void check_result(crossing_type got);
      crossing_type exp;
      if (pending.size() == 0) begin
         failures++;
         if (mismatches++ < 10)
            $display("unexpected result beat: hit=%0d x=%0d y=%0d clip=%0d",
                     got.hit, got.cross_x, got.cross_y, got.clipped);
         return;
      end
      exp = pending.pop_front();
      if (exp != got) begin
         failures++;
         if (mismatches++ < 10)
            $display({"mismatch: exp hit=%0d x=%0d y=%0d clip=%0d, ",
                      "got hit=%0d x=%0d y=%0d clip=%0d"},
                     exp.hit, exp.cross_x, exp.cross_y, exp.clipped,
                     got.hit, got.cross_x, got.cross_y, got.clipped);
      end
   endfunction
endclass

module tb_line_segment_intersection_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 300000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic signed [15:0]  req_p1_x = '0, req_p1_y = '0, req_p2_x = '0, req_p2_y = '0;
   logic signed [15:0]  req_p3_x = '0, req_p3_y = '0, req_p4_x = '0, req_p4_y = '0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic                rsp_hit;
   logic signed [15:0]  rsp_cross_x, rsp_cross_y;
   logic                rsp_clipped;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_segment_mode = 1'b0;

   crossing_scoreboard  crossings = new();
   int                  send_idle_pct = 0;
   int                  pop_idle_pct  = 0;
   longint              cycle_count   = 0;

   line_segment_intersection_top #(.COORD_WIDTH(16)) dut (
      .clock, .reset,
      .req_push, .req_full,
      .req_p1_x, .req_p1_y, .req_p2_x, .req_p2_y,
      .req_p3_x, .req_p3_y, .req_p4_x, .req_p4_y,
      .rsp_empty, .rsp_pop,
      .rsp_hit, .rsp_cross_x, .rsp_cross_y, .rsp_clipped,
      .csr_valid, .csr_ready, .csr_segment_mode
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels and the run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_segment_intersection_top verification failed");
         $finish;
      end
      if (!reset && req_push && !req_full)
         crossings.note_pair('{req_p1_x, req_p1_y, req_p2_x, req_p2_y,
                               req_p3_x, req_p3_y, req_p4_x, req_p4_y});
      if (!reset && rsp_pop && !rsp_empty)
         crossings.check_result('{rsp_hit, rsp_cross_x, rsp_cross_y, rsp_clipped});
   end

   // Random pop stalls.
   always @(posedge clock)
      rsp_pop <= !reset && ($urandom_range(99) >= pop_idle_pct);

   task automatic write_mode(bit mode);
      csr_valid        <= 1'b1;
      csr_segment_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      crossings.seg_mode = mode;
      csr_valid <= 1'b0;
   endtask

   task automatic send_pair(seg_pair_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_p1_x <= s[0]; req_p1_y <= s[1]; req_p2_x <= s[2]; req_p2_y <= s[3];
      req_p3_x <= s[4]; req_p3_y <= s[5]; req_p4_x <= s[6]; req_p4_y <= s[7];
      do @(posedge clock); while (!(req_push && !req_full));
   endtask

   task automatic send_directed();
      seg_pair_type set [$];
      set = '{
         '{0, 0, 4, 4, 0, 4, 4, 0},                       // plain crossing
         '{0, 0, 1, 1, 0, 1, 1, 0},                       // tie rounds up
         '{0, 0, -1, -1, 0, -1, -1, 0},                   // tie rounds away, negative
         '{0, 0, 4, 0, 0, 2, 4, 2},                       // parallel
         '{0, 0, 4, 0, 2, 0, 8, 0},                       // collinear overlap
         '{0, 0, 4, 4, 4, 4, 8, 0},                       // touch at end, t = 1
         '{0, 0, 4, 4, 0, 0, -4, 4},                      // touch at start, t = 0
         '{0, 0, 2, 2, 10, 0, 10, 5},                     // lines meet beyond segment
         '{-32768, 0, 32767, 1, -32768, 2, 32767, 2},     // far crossing, saturates
         '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768},
         '{32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767},
         '{-32768, -32768, -32768, -32768, 0, 0, 1, 1},   // degenerate point
         '{5, 5, 5, 5, 5, 5, 5, 5},
         '{-32768, 0, 32767, 0, 0, -32768, 0, 32767},
         '{1, -32768, 3, 32767, -32768, 7, 32767, -9}
      };
      foreach (set[i]) send_pair(set[i]);
   endtask

   function automatic seg_pair_type random_pair();
      seg_pair_type s;
      int span, k, d [2];
      case ($urandom_range(3))
         0: foreach (s[i]) s[i] = shortint'($urandom);
         1: begin
            span = $urandom_range(1) ? 64 : 4096;
            foreach (s[i]) s[i] = shortint'($urandom_range(2 * span) - span);
         end
         2: begin
            // second direction a multiple of the first
            foreach (s[i]) s[i] = shortint'($urandom_range(2000) - 1000);
            k = $urandom_range(6) - 3;
            d[0] = s[2] - s[0];
            d[1] = s[3] - s[1];
            s[6] = shortint'(s[4] + k * d[0]);
            s[7] = shortint'(s[5] + k * d[1]);
            if ($urandom_range(1)) begin
               s[4] = shortint'(s[0] + d[0] * 2);
               s[5] = shortint'(s[1] + d[1] * 2);
            end
         end
         default: begin
            // second segment starts on an endpoint of the first
            foreach (s[i]) s[i] = shortint'($urandom_range(20000) - 10000);
            k = $urandom_range(1) * 2;
            s[4] = s[k];
            s[5] = s[k + 1];
         end
      endcase
      return s;
   endfunction

   task automatic run_phase(bit mode, int send_pct, int pop_pct, int count, bit directed);
      write_mode(mode);
      send_idle_pct = send_pct;
      pop_idle_pct  = pop_pct;
      if (directed) send_directed();
      repeat (count) send_pair(random_pair());
      req_push <= 1'b0;
      while (crossings.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_phase(1'b1, 33, 74, 320, 1'b1);
      run_phase(1'b0, 74, 33, 320, 1'b1);
      run_phase(1'b1, 0, 0, 330, 1'b0);
      if (crossings.failures == 0 && crossings.pending.size() == 0) begin
         $display("line_segment_intersection_top verification clean");
      end else begin
         $display("line_segment_intersection_top verification failed");
      end
      $finish;
   end
endmodule

`default_nettype wire

/* line_segment_intersection_top.f */
+incdir+design
design/lsi_pkg.sv
design/lsi_queue.sv
design/lsi_front.sv
design/lsi_lane.sv
design/lsi_back.sv
design/line_segment_intersection_top.sv
dv/tb_line_segment_intersection_top.sv
